// ===== rtl/bdh_pkg.sv =====
// Package for the gated beam-crossing difference histogrammer.
// Holds field widths, store sizes, code types and the saturating increment.
// No dependencies; the interfaces, the core and the testbench import it.
package bdh_pkg;

    // Histogram geometry.
    localparam int NUM_SERVERS  = 8;
    localparam int NUM_CHANNELS = 14;
    localparam int NUM_BINS     = 128;
    localparam int NUM_LADDERS  = NUM_SERVERS * NUM_CHANNELS;
    localparam int COUNT_W      = 32;

    // Field widths.
    localparam int MODE_W = 2;
    localparam int MULT_W = 16;
    localparam int BIN_W  = 7;
    localparam int SID_W  = 12;
    localparam int CHAN_W = 8;
    localparam int SEL_W  = 7;

    // Store sizes and address widths.
    localparam int SRV_W     = $clog2(NUM_SERVERS);
    localparam int LAD_W     = $clog2(NUM_LADDERS);
    localparam int GLB_DEPTH = NUM_BINS;
    localparam int SRV_DEPTH = NUM_SERVERS * NUM_BINS;
    localparam int LAD_DEPTH = NUM_LADDERS * NUM_BINS;
    localparam int GLB_AW    = BIN_W;
    localparam int SRV_AW    = SRV_W + BIN_W;
    localparam int LAD_AW    = LAD_W + BIN_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MULT_W;

    localparam logic [MULT_W-1:0] MULT_MIN_RST    = MULT_W'(10);
    localparam logic [MULT_W-1:0] MULT_MAX_RST    = MULT_W'(100);
    localparam logic [SID_W-1:0]  SERVER_BASE_RST = SID_W'(3001);

    // Request kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_HEADER = 2'd0,
        MODE_HIT    = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULT_MIN    = 2'd0,
        REG_MULT_MAX    = 2'd1,
        REG_SERVER_BASE = 2'd2
    } reg_idx_t;

    // Which store a read request is answered from.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_GLOBAL,
        SRC_SERVER,
        SRC_LADDER
    } src_t;

    // Increment that sticks at the all-ones value.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== rtl/bdh_req_if.sv =====
// Request channel of the histogrammer: valid/ready plus the request fields.
// Depends on bdh_pkg for the field widths.
interface bdh_req_if;
    import bdh_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [MULT_W-1:0] multiplicity;
    logic [BIN_W-1:0]  bco_low;
    logic [BIN_W-1:0]  chip_bco;
    logic [SID_W-1:0]  server_id;
    logic [CHAN_W-1:0] channel;
    logic [SEL_W-1:0]  hist_select;
    logic [BIN_W-1:0]  bin_index;

    modport source (
        output valid, mode, multiplicity, bco_low, chip_bco, server_id, channel,
               hist_select, bin_index,
        input  ready
    );

    modport sink (
        input  valid, mode, multiplicity, bco_low, chip_bco, server_id, channel,
               hist_select, bin_index,
        output ready
    );
endinterface

// ===== rtl/bdh_rsp_if.sv =====
// Response channel of the histogrammer: valid/ready plus the read result.
// Depends on bdh_pkg for the count width.
interface bdh_rsp_if;
    import bdh_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] event_count;
    logic [COUNT_W-1:0] skipped_hits;

    modport source (
        output valid, bin_count, event_count, skipped_hits,
        input  ready
    );

    modport sink (
        input  valid, bin_count, event_count, skipped_hits,
        output ready
    );
endinterface

// ===== rtl/bdh_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents.
// No dependencies.
module bdh_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share one clock edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gated_bco_diff_histogrammer_core.sv =====
// Gated beam-crossing difference histogrammer, top level.
// Depends on bdh_pkg, bdh_req_if, bdh_rsp_if and bdh_ram.
//
// Usage:
//   The req channel carries event headers, hits and bin reads; a beat moves
//   when valid and ready are both high. A header opens or closes the event
//   window, a hit of an open event is binned by (chip_bco - bco_low) mod 128
//   in the global, server and half-ladder histograms. Only a bin read sends
//   a beat on the rsp channel: bin count plus both event and skip counters.
//   The cfg port writes mult_min, mult_max and server_base; the user must do
//   so only while idle; the block does not enforce it. Throughput: one request
//   per cycle unless stalled. Each histogram is a RAM with one read and one
//   write port; a hit reads in its accept cycle and writes the incremented
//   bin in the next cycle, with a bypass for back-to-back hits to the same
//   bin. A read result passes the second stage and the output queue before
//   rsp. Reset: the RAMs are swept to zero, one address per cycle over the
//   half-ladder depth; req.ready stays low meanwhile. Stall: results wait in a
//   two-entry output queue. Requests keep flowing while the queue has room for
//   every read in flight; otherwise req.ready drops until rsp takes a beat.
module gated_bco_diff_histogrammer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    bdh_req_if.sink                          req,
    bdh_rsp_if.source                        rsp,
    input  logic                             cfg_wr_en,
    input  logic [bdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bdh_pkg::*;

    // Configuration and event state.
    logic [MULT_W-1:0]  mult_min_reg;
    logic [MULT_W-1:0]  mult_max_reg;
    logic [SID_W-1:0]   server_base_reg;
    logic               event_open_reg;
    logic [COUNT_W-1:0] sel_cnt_reg;
    logic [COUNT_W-1:0] skip_cnt_reg;

    // Clearing sweep.
    logic               clr_busy_reg;
    logic [LAD_AW-1:0]  clr_addr_reg;

    // Second stage: RAM data arrives here.
    logic               s1_upd_g_reg;
    logic               s1_upd_s_reg;
    logic               s1_upd_l_reg;
    logic               s1_rd_reg;
    src_t               s1_src_reg;
    logic [GLB_AW-1:0]  s1_g_addr_reg;
    logic [SRV_AW-1:0]  s1_s_addr_reg;
    logic [LAD_AW-1:0]  s1_l_addr_reg;
    logic [COUNT_W-1:0] s1_sel_cnt_reg;
    logic [COUNT_W-1:0] s1_skip_cnt_reg;

    // Bypass of the last write into each RAM.
    logic               g_fwd_v_reg;
    logic [GLB_AW-1:0]  g_fwd_addr_reg;
    logic [COUNT_W-1:0] g_fwd_data_reg;
    logic               s_fwd_v_reg;
    logic [SRV_AW-1:0]  s_fwd_addr_reg;
    logic [COUNT_W-1:0] s_fwd_data_reg;
    logic               l_fwd_v_reg;
    logic [LAD_AW-1:0]  l_fwd_addr_reg;
    logic [COUNT_W-1:0] l_fwd_data_reg;

    // Output queue.
    logic [COUNT_W-1:0] q_bin_reg  [2];
    logic [COUNT_W-1:0] q_sel_reg  [2];
    logic [COUNT_W-1:0] q_skip_reg [2];
    logic               q_wr_ptr_reg;
    logic               q_rd_ptr_reg;
    logic [1:0]         q_cnt_reg;

    // Handshakes.
    logic accept;
    logic pop;
    logic push;
    logic room;

    // First-stage decode.
    logic               is_header;
    logic               is_hit;
    logic               is_read;
    logic               in_window;
    logic [BIN_W-1:0]   diff;
    logic [SID_W-1:0]   srv_off;
    logic               srv_ok;
    logic               chan_ok;
    logic [SRV_W-1:0]   hit_si;
    logic [LAD_W-1:0]   hit_li;
    logic [SEL_W-1:0]   sel_srv;
    logic [SEL_W-1:0]   sel_lad;
    src_t               rd_src;
    logic [BIN_W-1:0]   bin_sel;
    logic [SRV_W-1:0]   s_idx;
    logic [LAD_W-1:0]   l_idx;
    logic [GLB_AW-1:0]  g_raddr;
    logic [SRV_AW-1:0]  s_raddr;
    logic [LAD_AW-1:0]  l_raddr;

    // RAM ports.
    logic               g_we;
    logic [GLB_AW-1:0]  g_waddr;
    logic [COUNT_W-1:0] g_wdata;
    logic [COUNT_W-1:0] g_rdata;
    logic [COUNT_W-1:0] g_cur;
    logic               s_we;
    logic [SRV_AW-1:0]  s_waddr;
    logic [COUNT_W-1:0] s_wdata;
    logic [COUNT_W-1:0] s_rdata;
    logic [COUNT_W-1:0] s_cur;
    logic               l_we;
    logic [LAD_AW-1:0]  l_waddr;
    logic [COUNT_W-1:0] l_wdata;
    logic [COUNT_W-1:0] l_rdata;
    logic [COUNT_W-1:0] l_cur;
    logic [COUNT_W-1:0] rd_count;

    // A request may enter when the queue can hold every read in flight.
    assign room   = (q_cnt_reg == 2'd0) || ((q_cnt_reg == 2'd1) && !s1_rd_reg);
    assign pop    = rsp.valid && rsp.ready;
    assign push   = s1_rd_reg;
    assign req.ready = !clr_busy_reg && (room || pop);
    assign accept = req.valid && req.ready;

    // Request kind.
    assign is_header = accept && (req.mode == MODE_HEADER);
    assign is_hit    = accept && (req.mode == MODE_HIT) && event_open_reg;
    assign is_read   = accept && (req.mode == MODE_READ);
    assign in_window = (mult_min_reg < req.multiplicity) &&
                       (req.multiplicity < mult_max_reg);

    // Hit mapping: timing difference, server and half-ladder index.
    assign diff    = req.chip_bco - req.bco_low;
    assign srv_off = req.server_id - server_base_reg;
    assign srv_ok  = (req.server_id >= server_base_reg) &&
                     (srv_off < SID_W'(NUM_SERVERS));
    assign chan_ok = req.channel < CHAN_W'(NUM_CHANNELS);
    assign hit_si  = srv_off[SRV_W-1:0];
    assign hit_li  = LAD_W'(LAD_W'(hit_si) * LAD_W'(NUM_CHANNELS)) +
                     LAD_W'(req.channel);

    // Read mapping: which histogram the selector names.
    assign sel_srv = req.hist_select - SEL_W'(1);
    assign sel_lad = req.hist_select - SEL_W'(1 + NUM_SERVERS);

    always_comb
    begin
        if (req.hist_select == '0)
        begin
            rd_src = SRC_GLOBAL;
        end
        else if (req.hist_select <= SEL_W'(NUM_SERVERS))
        begin
            rd_src = SRC_SERVER;
        end
        else if (req.hist_select < SEL_W'(1 + NUM_SERVERS + NUM_LADDERS))
        begin
            rd_src = SRC_LADDER;
        end
        else
        begin
            rd_src = SRC_NONE;
        end
    end

    // Read addresses, shared between hits and bin reads.
    assign bin_sel = (req.mode == MODE_READ) ? req.bin_index : diff;
    assign s_idx   = (req.mode == MODE_READ) ? sel_srv[SRV_W-1:0] : hit_si;
    assign l_idx   = (req.mode == MODE_READ) ? sel_lad[LAD_W-1:0] : hit_li;
    assign g_raddr = bin_sel;
    assign s_raddr = {s_idx, bin_sel};
    assign l_raddr = {l_idx, bin_sel};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_min_reg    <= MULT_MIN_RST;
            mult_max_reg    <= MULT_MAX_RST;
            server_base_reg <= SERVER_BASE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MULT_MIN:    mult_min_reg    <= cfg_data;
                REG_MULT_MAX:    mult_max_reg    <= cfg_data;
                REG_SERVER_BASE: server_base_reg <= cfg_data[SID_W-1:0];
                default:         ;
            endcase
        end
    end

    // Event window and the two counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_open_reg <= 1'b0;
            sel_cnt_reg    <= '0;
            skip_cnt_reg   <= '0;
        end
        else
        begin
            if (is_header)
            begin
                event_open_reg <= in_window;
                if (in_window)
                begin
                    sel_cnt_reg <= sat_inc(sel_cnt_reg);
                end
            end
            if (is_hit && !(srv_ok && chan_ok))
            begin
                skip_cnt_reg <= sat_inc(skip_cnt_reg);
            end
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + LAD_AW'(1);
            if (clr_addr_reg == LAD_AW'(LAD_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Second-stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_upd_g_reg <= 1'b0;
            s1_upd_s_reg <= 1'b0;
            s1_upd_l_reg <= 1'b0;
            s1_rd_reg    <= 1'b0;
            s1_src_reg   <= SRC_NONE;
        end
        else
        begin
            s1_upd_g_reg <= is_hit;
            s1_upd_s_reg <= is_hit && srv_ok;
            s1_upd_l_reg <= is_hit && srv_ok && chan_ok;
            s1_rd_reg    <= is_read;
            s1_src_reg   <= rd_src;
        end
    end

    // Second-stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_g_addr_reg   <= g_raddr;
            s1_s_addr_reg   <= s_raddr;
            s1_l_addr_reg   <= l_raddr;
            s1_sel_cnt_reg  <= sel_cnt_reg;
            s1_skip_cnt_reg <= skip_cnt_reg;
        end
    end

    // Current bin values, with the previous cycle's write bypassed in.
    assign g_cur = (g_fwd_v_reg && (g_fwd_addr_reg == s1_g_addr_reg)) ?
                   g_fwd_data_reg : g_rdata;
    assign s_cur = (s_fwd_v_reg && (s_fwd_addr_reg == s1_s_addr_reg)) ?
                   s_fwd_data_reg : s_rdata;
    assign l_cur = (l_fwd_v_reg && (l_fwd_addr_reg == s1_l_addr_reg)) ?
                   l_fwd_data_reg : l_rdata;

    // Write ports: the sweep writes zeros, otherwise hits write back.
    assign g_we    = clr_busy_reg ? (clr_addr_reg < LAD_AW'(GLB_DEPTH)) : s1_upd_g_reg;
    assign g_waddr = clr_busy_reg ? clr_addr_reg[GLB_AW-1:0] : s1_g_addr_reg;
    assign g_wdata = clr_busy_reg ? '0 : sat_inc(g_cur);
    assign s_we    = clr_busy_reg ? (clr_addr_reg < LAD_AW'(SRV_DEPTH)) : s1_upd_s_reg;
    assign s_waddr = clr_busy_reg ? clr_addr_reg[SRV_AW-1:0] : s1_s_addr_reg;
    assign s_wdata = clr_busy_reg ? '0 : sat_inc(s_cur);
    assign l_we    = clr_busy_reg ? 1'b1 : s1_upd_l_reg;
    assign l_waddr = clr_busy_reg ? clr_addr_reg : s1_l_addr_reg;
    assign l_wdata = clr_busy_reg ? '0 : sat_inc(l_cur);

    // Bypass registers follow the hit write-backs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_fwd_v_reg <= 1'b0;
            s_fwd_v_reg <= 1'b0;
            l_fwd_v_reg <= 1'b0;
        end
        else
        begin
            g_fwd_v_reg <= s1_upd_g_reg;
            s_fwd_v_reg <= s1_upd_s_reg;
            l_fwd_v_reg <= s1_upd_l_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_fwd_addr_reg <= s1_g_addr_reg;
        g_fwd_data_reg <= g_wdata;
        s_fwd_addr_reg <= s1_s_addr_reg;
        s_fwd_data_reg <= s_wdata;
        l_fwd_addr_reg <= s1_l_addr_reg;
        l_fwd_data_reg <= l_wdata;
    end

    // Histogram stores.
    bdh_ram #(.WIDTH(COUNT_W), .DEPTH(GLB_DEPTH)) u_glb_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    bdh_ram #(.WIDTH(COUNT_W), .DEPTH(SRV_DEPTH)) u_srv_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    bdh_ram #(.WIDTH(COUNT_W), .DEPTH(LAD_DEPTH)) u_lad_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // Bin value of a read request.
    always_comb
    begin
        case (s1_src_reg)
            SRC_GLOBAL: rd_count = g_cur;
            SRC_SERVER: rd_count = s_cur;
            SRC_LADDER: rd_count = l_cur;
            default:    rd_count = '0;
        endcase
    end

    // Output queue pointers and fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
            if (push && !pop)
            begin
                q_cnt_reg <= q_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                q_cnt_reg <= q_cnt_reg - 2'd1;
            end
        end
    end

    // Output queue entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_bin_reg[q_wr_ptr_reg]  <= rd_count;
            q_sel_reg[q_wr_ptr_reg]  <= s1_sel_cnt_reg;
            q_skip_reg[q_wr_ptr_reg] <= s1_skip_cnt_reg;
        end
    end

    assign rsp.valid        = (q_cnt_reg != 2'd0);
    assign rsp.bin_count    = q_bin_reg[q_rd_ptr_reg];
    assign rsp.event_count  = q_sel_reg[q_rd_ptr_reg];
    assign rsp.skipped_hits = q_skip_reg[q_rd_ptr_reg];

`ifndef NO_ASSERTIONS
    // No request enters while the stores are being swept.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.ready)
        else $error("request accepted during clearing sweep");

    // A read reaching the queue always finds a free entry.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_rd_reg |-> ((q_cnt_reg != 2'd2) || pop))
        else $error("output queue overflow");

    // A half-ladder update always comes with server and global updates.
    a_update_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        s1_upd_l_reg |-> (s1_upd_s_reg && s1_upd_g_reg))
        else $error("half-ladder update without server or global update");

    // The selected-event counter never goes down.
    a_sel_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (sel_cnt_reg >= $past(sel_cnt_reg)))
        else $error("selected event counter decreased");
`endif

endmodule

// ===== tb/sv/gated_bco_diff_histogrammer_core_tb.sv =====
// Self-checking testbench for the gated beam-crossing difference histogrammer.
// Drives header, hit and bin-read beats and checks every read result against a
// typed value or a local histogram predictor. Depends on every file under rtl.
module gated_bco_diff_histogrammer_core_tb;
    import bdh_pkg::*;

    localparam logic [MODE_W-1:0]  MODE_SPARE    = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_ALL     = {COUNT_W{1'b1}};
    localparam int                 DIR_ROWS      = 25;
    localparam int                 SEG_COUNT     = 6;
    localparam int                 SEG_ITEMS     = 250;
    localparam int                 SETTLE_CYCLES = 8;
    localparam int                 HOLD_CYCLES   = 400;
    localparam int                 CYCLE_LIMIT   = 400000;

    // Register settings and idle rates of the random segments.
    localparam int SEG_MIN [SEG_COUNT] = '{0, 65535, 20, 300, 50, 0};
    localparam int SEG_MAX [SEG_COUNT] = '{65535, 0, 22, 5000, 60000, 2};
    localparam int SEG_BASE [SEG_COUNT] = '{0, 2000, 4090, 4095, 3001, 4088};
    localparam int SEG_SND_IDLE [SEG_COUNT] = '{18, 18, 78, 78, 0, 0};
    localparam int SEG_RCV_IDLE [SEG_COUNT] = '{78, 78, 18, 18, 0, 0};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MULT_W-1:0] multiplicity;
        logic [BIN_W-1:0]  bco_low;
        logic [BIN_W-1:0]  chip_bco;
        logic [SID_W-1:0]  server_id;
        logic [CHAN_W-1:0] channel;
        logic [SEL_W-1:0]  hist_select;
        logic [BIN_W-1:0]  bin_index;
    } req_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [COUNT_W-1:0] event_count;
        logic [COUNT_W-1:0] skipped_hits;
    } read_result_t;

    typedef struct packed {
        bit           typed;
        req_beat_t    beat;
        read_result_t result;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bdh_req_if req();
    bdh_rsp_if rsp();

    gated_bco_diff_histogrammer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow histograms, counters and register copies.
    logic [COUNT_W-1:0] glb_bins [GLB_DEPTH];
    logic [COUNT_W-1:0] srv_bins [SRV_DEPTH];
    logic [COUNT_W-1:0] lad_bins [LAD_DEPTH];
    bit                 event_sel;
    logic [COUNT_W-1:0] sel_events;
    logic [COUNT_W-1:0] skip_hits;
    logic [MULT_W-1:0]  win_lo;
    logic [MULT_W-1:0]  win_hi;
    logic [SID_W-1:0]   base_sid;

    read_result_t expected_reads[$];
    dir_row_t     dir_rows [DIR_ROWS];

    int  snd_idle_pct = 18;
    int  rcv_idle_pct = 78;
    bit  hold_request = 1'b0;
    int  fail_count = 0;
    int  reads_checked = 0;
    int  n_header = 0;
    int  n_hit = 0;
    int  n_read = 0;
    int  n_spare = 0;
    int  cycle_count = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Applies one accepted beat to the shadow state; returns 1 with the
    // read result when the beat is a bin read.
    function automatic bit histogram_step(input req_beat_t b, output read_result_t res);
        logic [BIN_W-1:0] diff;
        int off;
        int lad;
        res = '0;
        diff = b.chip_bco - b.bco_low;
        off = int'(b.server_id) - int'(base_sid);
        lad = int'(b.hist_select) - 1 - NUM_SERVERS;
        case (b.mode)
            MODE_HEADER:
            begin
                event_sel = (b.multiplicity > win_lo) && (b.multiplicity < win_hi);
                if (event_sel && sel_events != COUNT_ALL)
                    sel_events++;
                return 1'b0;
            end
            MODE_HIT:
            begin
                if (!event_sel)
                    return 1'b0;
                if (glb_bins[diff] != COUNT_ALL)
                    glb_bins[diff]++;
                // A server outside the mapped range only reaches the global histogram.
                if (off < 0 || off >= NUM_SERVERS)
                begin
                    if (skip_hits != COUNT_ALL)
                        skip_hits++;
                    return 1'b0;
                end
                if (srv_bins[off * NUM_BINS + int'(diff)] != COUNT_ALL)
                    srv_bins[off * NUM_BINS + int'(diff)]++;
                if (b.channel >= NUM_CHANNELS)
                begin
                    if (skip_hits != COUNT_ALL)
                        skip_hits++;
                end
                else if (lad_bins[(off * NUM_CHANNELS + int'(b.channel)) * NUM_BINS
                                  + int'(diff)] != COUNT_ALL)
                begin
                    lad_bins[(off * NUM_CHANNELS + int'(b.channel)) * NUM_BINS
                             + int'(diff)]++;
                end
                return 1'b0;
            end
            MODE_READ:
            begin
                // An unknown histogram reads as zero.
                if (b.hist_select == 0)
                    res.bin_count = glb_bins[b.bin_index];
                else if (b.hist_select <= NUM_SERVERS)
                    res.bin_count = srv_bins[(int'(b.hist_select) - 1) * NUM_BINS
                                             + int'(b.bin_index)];
                else if (lad < NUM_LADDERS)
                    res.bin_count = lad_bins[lad * NUM_BINS + int'(b.bin_index)];
                res.event_count = sel_events;
                res.skipped_hits = skip_hits;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] exp_v,
                                        input logic [COUNT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Offers one beat after a random gap and waits for the handshake.
    task automatic send_beat(input req_beat_t b, input bit typed, input read_result_t typed_res);
        read_result_t res;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.mode         <= b.mode;
        req.multiplicity <= b.multiplicity;
        req.bco_low      <= b.bco_low;
        req.chip_bco     <= b.chip_bco;
        req.server_id    <= b.server_id;
        req.channel      <= b.channel;
        req.hist_select  <= b.hist_select;
        req.bin_index    <= b.bin_index;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        case (b.mode)
            MODE_HEADER: n_header++;
            MODE_HIT:    n_hit++;
            MODE_READ:   n_read++;
            default:     n_spare++;
        endcase
        if (histogram_step(b, res))
            expected_reads.push_back(typed ? typed_res : res);
    endtask

    // Writes all three registers on consecutive cycles; the block is idle.
    task automatic apply_settings(input int lo, input int hi, input int base);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MULT_MIN;
        cfg_data  <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= REG_MULT_MAX;
        cfg_data  <= CFG_DATA_W'(hi);
        @(posedge clk);
        cfg_index <= REG_SERVER_BASE;
        cfg_data  <= CFG_DATA_W'(base);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        win_lo   = MULT_W'(lo);
        win_hi   = MULT_W'(hi);
        base_sid = SID_W'(base);
    endtask

    // Waits until every read result is in, then lets the hit pipeline settle.
    task automatic drain;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure, one long hold on request, checking.
    initial
    begin
        read_result_t exp_r;
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_reads.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with no read pending, got %0d %0d %0d",
                             $time, rsp.bin_count, rsp.event_count, rsp.skipped_hits);
                end
                else
                begin
                    exp_r = expected_reads.pop_front();
                    reads_checked++;
                    check_field("bin_count", exp_r.bin_count, rsp.bin_count);
                    check_field("event_count", exp_r.event_count,
                                rsp.event_count);
                    check_field("skipped_hits", exp_r.skipped_hits, rsp.skipped_hits);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d reads still pending",
                 cycle_count, expected_reads.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Reset, directed table, then random segments under changing settings.
    initial
    begin
        req_beat_t b;
        read_result_t no_res;
        int seg;
        int sent;
        int pick;
        int lo_i;
        int hi_i;
        int off;
        logic [BIN_W-1:0] last_diff;
        logic [SEL_W-1:0] last_srv_sel;
        logic [SEL_W-1:0] last_lad_sel;

        no_res = '0;
        last_diff = '0;
        last_srv_sel = '0;
        last_lad_sel = '0;

        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_MULT_MIN;
        cfg_data         <= '0;
        req.valid        <= 1'b0;
        req.mode         <= MODE_HEADER;
        req.multiplicity <= '0;
        req.bco_low      <= '0;
        req.chip_bco     <= '0;
        req.server_id    <= '0;
        req.channel      <= '0;
        req.hist_select  <= '0;
        req.bin_index    <= '0;

        foreach (glb_bins[i]) glb_bins[i] = '0;
        foreach (srv_bins[i]) srv_bins[i] = '0;
        foreach (lad_bins[i]) lad_bins[i] = '0;
        event_sel  = 1'b0;
        sel_events = '0;
        skip_hits  = '0;
        win_lo     = MULT_MIN_RST;
        win_hi     = MULT_MAX_RST;
        base_sid   = SERVER_BASE_RST;

        // Directed rows under reset settings (window 10..100, base 3001).
        // Fields: mode, multiplicity, bco_low, chip_bco, server_id, channel,
        // hist_select, bin_index. Typed results are bin, events, skipped.
        dir_rows[0]  = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         '{32'd0, 32'd0, 32'd0}};
        dir_rows[1]  = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd120, 7'd127},
                         '{32'd0, 32'd0, 32'd0}};
        dir_rows[2]  = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd127, 7'd5},
                         '{32'd0, 32'd0, 32'd0}};
        // A hit before any header is dropped.
        dir_rows[3]  = '{1'b0, '{MODE_HIT, 16'd0, 7'd3, 7'd5, 12'd3001, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[4]  = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd2},
                         '{32'd0, 32'd0, 32'd0}};
        // Both window bounds are exclusive.
        dir_rows[5]  = '{1'b0, '{MODE_HEADER, 16'd10, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[6]  = '{1'b0, '{MODE_HEADER, 16'd100, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[7]  = '{1'b0, '{MODE_HEADER, 16'd11, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        // Wrapping difference, then bad server, bad channel and far-off server.
        dir_rows[8]  = '{1'b0, '{MODE_HIT, 16'd0, 7'd127, 7'd0, 12'd3001, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[9]  = '{1'b0, '{MODE_HIT, 16'd0, 7'd0, 7'd127, 12'd3009, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[10] = '{1'b0, '{MODE_HIT, 16'd0, 7'd64, 7'd64, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[11] = '{1'b0, '{MODE_HIT, 16'd0, 7'd10, 7'd20, 12'd3008, 8'd14, 7'd0, 7'd0},
                         no_res};
        dir_rows[12] = '{1'b0, '{MODE_HIT, 16'd0, 7'd0, 7'd0, 12'd3008, 8'd255, 7'd0, 7'd0},
                         no_res};
        dir_rows[13] = '{1'b0, '{MODE_HIT, 16'd0, 7'd1, 7'd1, 12'd4095, 8'd13, 7'd0, 7'd0},
                         no_res};
        // The spare mode is ignored.
        dir_rows[14] = '{1'b0, '{MODE_SPARE, 16'hFFFF, 7'd127, 7'd127, 12'd4095, 8'd255,
                                 7'd127, 7'd127}, no_res};
        dir_rows[15] = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd1},
                         '{32'd1, 32'd1, 32'd5}};
        dir_rows[16] = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd1, 7'd1},
                         '{32'd1, 32'd1, 32'd5}};
        dir_rows[17] = '{1'b1, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd9, 7'd1},
                         '{32'd1, 32'd1, 32'd5}};
        dir_rows[18] = '{1'b0, '{MODE_HEADER, 16'd99, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        // Last half-ladder of the last server.
        dir_rows[19] = '{1'b0, '{MODE_HIT, 16'd0, 7'd85, 7'd42, 12'd3008, 8'd13, 7'd0, 7'd0},
                         no_res};
        dir_rows[20] = '{1'b0, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd120, 7'd85},
                         no_res};
        // An unselected header closes the event, so the next hit is dropped.
        dir_rows[21] = '{1'b0, '{MODE_HEADER, 16'hFFFF, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[22] = '{1'b0, '{MODE_HIT, 16'd0, 7'd0, 7'd0, 12'd3000, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[23] = '{1'b0, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd0, 7'd0},
                         no_res};
        dir_rows[24] = '{1'b0, '{MODE_READ, 16'd0, 7'd0, 7'd0, 12'd0, 8'd0, 7'd8, 7'd10},
                         no_res};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first beat waits out the store clearing sweep on ready.
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].result);
        req.valid <= 1'b0;
        drain();

        for (seg = 0; seg < SEG_COUNT; seg++)
        begin
            snd_idle_pct = SEG_SND_IDLE[seg];
            rcv_idle_pct = SEG_RCV_IDLE[seg];
            apply_settings(SEG_MIN[seg], SEG_MAX[seg], SEG_BASE[seg]);
            // Long result hold while requests keep coming, to fill the block.
            if (seg == 4)
                hold_request = 1'b1;
            lo_i = int'(win_lo);
            hi_i = int'(win_hi);
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                b.multiplicity = MULT_W'($urandom);
                b.bco_low      = BIN_W'($urandom);
                b.chip_bco     = BIN_W'($urandom);
                b.server_id    = SID_W'($urandom);
                b.channel      = CHAN_W'($urandom);
                b.hist_select  = SEL_W'($urandom);
                b.bin_index    = BIN_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    // Headers mostly open an event; the rest take a bound, zero, all ones or a random value.
                    b.mode = MODE_HEADER;
                    if (hi_i - lo_i >= 2 && $urandom_range(0, 99) < 80)
                    begin
                        b.multiplicity = MULT_W'($urandom_range(lo_i + 1, hi_i - 1));
                    end
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0: b.multiplicity = win_lo;
                            1: b.multiplicity = win_hi;
                            2: b.multiplicity = '0;
                            3: b.multiplicity = '1;
                            default: ;
                        endcase
                    end
                end
                else if (pick < 70)
                begin
                    // Hits mostly land on mapped servers and channels.
                    b.mode = MODE_HIT;
                    if ($urandom_range(0, 99) < 75)
                        b.server_id = base_sid + SID_W'($urandom_range(0, NUM_SERVERS - 1));
                    if ($urandom_range(0, 99) < 80)
                        b.channel = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
                    last_diff = b.chip_bco - b.bco_low;
                    off = int'(b.server_id) - int'(base_sid);
                    if (off >= 0 && off < NUM_SERVERS)
                    begin
                        last_srv_sel = SEL_W'(off + 1);
                        if (b.channel < NUM_CHANNELS)
                            last_lad_sel = SEL_W'(1 + NUM_SERVERS + off * NUM_CHANNELS
                                                  + int'(b.channel));
                    end
                end
                else if (pick < 94)
                begin
                    // Reads favor the histograms and bin that were just filled.
                    b.mode = MODE_READ;
                    pick = $urandom_range(0, 99);
                    if (pick < 20)
                        b.hist_select = '0;
                    else if (pick < 40)
                        b.hist_select = last_srv_sel;
                    else if (pick < 60)
                        b.hist_select = last_lad_sel;
                    else if (pick < 90)
                        b.hist_select = SEL_W'($urandom_range(0, NUM_LADDERS + NUM_SERVERS));
                    else
                        b.hist_select = SEL_W'($urandom_range(NUM_LADDERS + NUM_SERVERS + 1,
                                                              127));
                    if ($urandom_range(0, 99) < 60)
                        b.bin_index = last_diff;
                end
                else
                begin
                    b.mode = MODE_SPARE;
                end
                send_beat(b, 1'b0, no_res);
                if (b.mode != MODE_SPARE)
                    sent++;
            end
            req.valid <= 1'b0;
            drain();
        end

        if (expected_reads.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d read results never arrived", $time, expected_reads.size());
        end
        $display("Covered %0d headers, %0d hits, %0d reads and %0d spare beats over %0d settings.",
                 n_header, n_hit, n_read, n_spare, SEG_COUNT + 1);
        $display("Checked %0d read results in %0d cycles, %0d mismatches.",
                 reads_checked, cycle_count, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdh_pkg.sv
rtl/bdh_req_if.sv
rtl/bdh_rsp_if.sv
rtl/bdh_ram.sv
rtl/gated_bco_diff_histogrammer_core.sv
tb/sv/gated_bco_diff_histogrammer_core_tb.sv
